FILE: rtl/core/bepr_pkg.sv
// ----------------------------------------------------------------------------
// bepr_pkg
// Shared types and constants for the binomial European option pricer.
// ----------------------------------------------------------------------------
package bepr_pkg;

	// Number of Taylor terms past the constant one in the e^r series.
	localparam int unsigned EXP_TERMS = 13;

	typedef struct packed {
		logic [31:0] spot_price;
		logic [31:0] up_factor;
		logic [31:0] down_factor;
		logic [15:0] rate;
		logic [6:0]  periods;
		logic [31:0] strike;
		logic        compound_select;
		logic        put_select;
	} in_item_t;

	typedef struct packed {
		logic [31:0] option_price;
		logic        bad_factors;
	} out_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_EXP_MUL,
		ST_EXP_DIV,
		ST_EXP_WAIT,
		ST_EXP_END,
		ST_PROB,
		ST_PROB_WAIT,
		ST_DISC,
		ST_DISC_WAIT,
		ST_LEAF_START,
		ST_LEAF_CHK,
		ST_LEAF_U,
		ST_LEAF_WR,
		ST_LEAF_D,
		ST_FOLD_LVL,
		ST_FOLD_LDA,
		ST_FOLD_LDB,
		ST_FOLD_M1,
		ST_FOLD_M2,
		ST_FOLD_M3,
		ST_FOLD_WR,
		ST_DONE
	} state_t;

endpackage

FILE: rtl/core/binomial_european_option_pricer_core.sv
// ----------------------------------------------------------------------------
// binomial_european_option_pricer_core
// Prices one European call or put per request on a binomial tree.
// ----------------------------------------------------------------------------
// A request transfers on in_valid/in_ready; the price leaves on
// out_valid/out_ready. in_ready is high only while the sequencer is idle, so
// one request is worked on at a time. A single multiplier and one restoring
// divider are shared across the steps. Per request, with T periods after
// clamping to MAX_PERIODS, the steps run in this order:
//   e^r setup (compound only)
//   probability and discount
//   terminal nodes
//   backward fold through the node store
// Bad factors (up not above down) skip these steps and go straight to the
// result. The result sits in an output register; a request can transfer in
// while it waits, and the next result is held back until the receiver takes
// the previous one. Reset empties the output register and returns the
// sequencer to idle; the node store is not cleared.
// ----------------------------------------------------------------------------
module binomial_european_option_pricer_core #(
	parameter int MAX_PERIODS = 64,
	parameter int FRAC_BITS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bepr_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output bepr_pkg::out_item_t out_item
);
	import bepr_pkg::*;

	localparam int DEPTH = MAX_PERIODS + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (AW > 7) ? AW : 7;
	localparam int GW    = FRAC_BITS + 3;
	localparam int PW    = FRAC_BITS + 1;
	localparam int DW    = (2 * FRAC_BITS + 2 > 33) ? 2 * FRAC_BITS + 2 : 33;
	localparam logic [GW-1:0] ONE_G = GW'(1) << FRAC_BITS;
	localparam logic [DW-1:0] ONE_D = DW'(1) << FRAC_BITS;

	state_t state_q, state_d;

	// Request fields.
	logic [31:0] spot_q, up_q, down_q, strike_q;
	logic [15:0] rate_q;
	logic        put_q;
	logic [AW-1:0] t_q;

	// Datapath.
	logic [32:0] term_q;
	logic [34:0] sum_q;
	logic [3:0]  k_q;
	logic [GW-1:0] g_q;
	logic [PW-1:0] p_q, q_q, disc_q;
	logic [31:0] a_q, b_q, s_q, mix_q, res_q;
	logic [65:0] acc_q, prod_q;
	logic [AW-1:0] i_q, lvl_q, cnt_q;
	logic        bad_q;

	logic          out_valid_q;
	out_item_t     out_item_q;

	// Shared multiplier operands.
	logic [32:0] mul_a, mul_b;
	logic [65:0] prod_shift;
	logic [31:0] prod_sat;

	// Divider.
	logic          div_start, div_busy, div_done;
	logic [DW-1:0] div_dividend, div_quotient;
	logic [31:0]   div_divisor;

	// Node store.
	logic [31:0]   node_mem [DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata, rd_q;

	logic [CW-1:0] periods_w, tcl_w;
	logic [31:0]   payoff;
	logic [AW:0]   i_next2;
	logic          leaf_last, fold_last;

	assign periods_w = CW'(in_item.periods);
	assign tcl_w     = (periods_w > CW'(MAX_PERIODS)) ? CW'(MAX_PERIODS) : periods_w;
	assign prod_shift = prod_q >> FRAC_BITS;
	assign prod_sat   = (|prod_shift[65:32]) ? 32'hFFFF_FFFF : prod_shift[31:0];
	assign i_next2    = {1'b0, i_q} + (AW+1)'(2);
	assign leaf_last  = i_q == t_q;
	assign fold_last  = ({1'b0, i_q} + (AW+1)'(1)) == {1'b0, lvl_q};

	always_comb begin
		if (put_q) begin
			payoff = (strike_q > s_q) ? strike_q - s_q : 32'd0;
		end else begin
			payoff = (s_q > strike_q) ? s_q - strike_q : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		mul_a        = '0;
		mul_b        = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		mem_we       = 1'b0;
		mem_waddr    = i_q;
		mem_wdata    = payoff;
		mem_raddr    = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_item.up_factor <= in_item.down_factor) begin
						state_d = ST_DONE;
					end else if (in_item.compound_select) begin
						state_d = ST_EXP_MUL;
					end else begin
						state_d = ST_PROB;
					end
				end
			end
			ST_EXP_MUL: begin
				mul_a   = term_q;
				mul_b   = {1'b0, rate_q, 16'd0};
				state_d = ST_EXP_DIV;
			end
			ST_EXP_DIV: begin
				div_start    = 1'b1;
				div_dividend = DW'(prod_q[64:32]);
				div_divisor  = 32'(k_q);
				state_d      = ST_EXP_WAIT;
			end
			ST_EXP_WAIT: begin
				if (div_done) begin
					state_d = (k_q == 4'(EXP_TERMS)) ? ST_EXP_END : ST_EXP_MUL;
				end
			end
			ST_EXP_END: state_d = ST_PROB;
			ST_PROB: begin
				if (32'(g_q) <= down_q) begin
					state_d = ST_DISC;
				end else begin
					div_start    = 1'b1;
					div_dividend = DW'(32'(g_q) - down_q) << FRAC_BITS;
					div_divisor  = up_q - down_q;
					state_d      = ST_PROB_WAIT;
				end
			end
			ST_PROB_WAIT: if (div_done) state_d = ST_DISC;
			ST_DISC: begin
				div_start    = 1'b1;
				div_dividend = DW'(1) << (2 * FRAC_BITS);
				div_divisor  = 32'(g_q);
				state_d      = ST_DISC_WAIT;
			end
			ST_DISC_WAIT: if (div_done) state_d = ST_LEAF_START;
			ST_LEAF_START: state_d = ST_LEAF_CHK;
			ST_LEAF_CHK: begin
				if (cnt_q == '0) begin
					state_d = ST_LEAF_WR;
				end else begin
					mul_a   = {1'b0, s_q};
					mul_b   = {1'b0, up_q};
					state_d = ST_LEAF_U;
				end
			end
			ST_LEAF_U: state_d = ST_LEAF_CHK;
			ST_LEAF_WR: begin
				mem_we    = 1'b1;
				mem_wdata = payoff;
				if (leaf_last) begin
					state_d = ST_FOLD_LVL;
				end else begin
					mul_a   = {1'b0, a_q};
					mul_b   = {1'b0, down_q};
					state_d = ST_LEAF_D;
				end
			end
			ST_LEAF_D: state_d = ST_LEAF_START;
			ST_FOLD_LVL: begin
				mem_raddr = '0;
				state_d   = (lvl_q == '0) ? ST_DONE : ST_FOLD_LDA;
			end
			ST_FOLD_LDA: begin
				mem_raddr = AW'(1);
				state_d   = ST_FOLD_LDB;
			end
			ST_FOLD_LDB: begin
				mul_a   = 33'(p_q);
				mul_b   = {1'b0, a_q};
				state_d = ST_FOLD_M1;
			end
			ST_FOLD_M1: begin
				mul_a   = 33'(q_q);
				mul_b   = {1'b0, b_q};
				state_d = ST_FOLD_M2;
			end
			ST_FOLD_M2: state_d = ST_FOLD_M3;
			ST_FOLD_M3: begin
				mul_a   = {1'b0, mix_q};
				mul_b   = 33'(disc_q);
				state_d = ST_FOLD_WR;
			end
			ST_FOLD_WR: begin
				mem_we    = 1'b1;
				mem_wdata = prod_sat;
				mem_raddr = i_next2[AW-1:0];
				state_d   = fold_last ? ST_FOLD_LVL : ST_FOLD_LDB;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		rd_q   <= node_mem[mem_raddr];
		if (mem_we) begin
			node_mem[mem_waddr] <= mem_wdata;
		end
	end

	// Datapath registers follow the sequencer.
	always_ff @(posedge clk) begin
		if (mem_we && mem_waddr == '0) begin
			res_q <= mem_wdata;
		end
		case (state_q)
			ST_IDLE: begin
				spot_q   <= in_item.spot_price;
				up_q     <= in_item.up_factor;
				down_q   <= in_item.down_factor;
				rate_q   <= in_item.rate;
				strike_q <= in_item.strike;
				put_q    <= in_item.put_select;
				t_q      <= tcl_w[AW-1:0];
				bad_q    <= in_item.up_factor <= in_item.down_factor;
				res_q    <= '0;
				term_q   <= 33'h1_0000_0000;
				sum_q    <= 35'h1_0000_0000;
				k_q      <= 4'd1;
				g_q      <= ONE_G + GW'(({in_item.rate, FRAC_BITS'(0)}) >> 16);
			end
			ST_EXP_WAIT: begin
				if (div_done) begin
					term_q <= div_quotient[32:0];
					sum_q  <= sum_q + 35'(div_quotient[32:0]);
					k_q    <= k_q + 4'd1;
				end
			end
			ST_EXP_END: g_q <= GW'(sum_q >> (32 - FRAC_BITS));
			ST_PROB: begin
				p_q <= '0;
				q_q <= PW'(ONE_G);
			end
			ST_PROB_WAIT: begin
				if (div_done) begin
					if (div_quotient > ONE_D) begin
						p_q <= PW'(ONE_G);
						q_q <= '0;
					end else begin
						p_q <= div_quotient[PW-1:0];
						q_q <= PW'(ONE_G) - div_quotient[PW-1:0];
					end
				end
			end
			ST_DISC_WAIT: begin
				disc_q <= div_quotient[PW-1:0];
				i_q    <= '0;
				a_q    <= spot_q;
			end
			ST_LEAF_START: begin
				s_q   <= a_q;
				cnt_q <= t_q - i_q;
			end
			ST_LEAF_U: begin
				s_q   <= prod_sat;
				cnt_q <= cnt_q - AW'(1);
			end
			ST_LEAF_WR: begin
				if (leaf_last) begin
					i_q   <= '0;
					lvl_q <= t_q;
				end
			end
			ST_LEAF_D: begin
				a_q <= prod_sat;
				i_q <= i_q + AW'(1);
			end
			ST_FOLD_LDA: a_q <= rd_q;
			ST_FOLD_LDB: b_q <= rd_q;
			ST_FOLD_M1:  acc_q <= prod_q;
			ST_FOLD_M2:  mix_q <= 32'((acc_q + prod_q) >> FRAC_BITS);
			ST_FOLD_WR: begin
				a_q <= b_q;
				if (fold_last) begin
					i_q   <= '0;
					lvl_q <= lvl_q - AW'(1);
				end else begin
					i_q <= i_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	bepr_divider #(
		.DW(DW)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			out_item_q.option_price <= bad_q ? 32'd0 : res_q;
			out_item_q.bad_factors  <= bad_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// The divider is never restarted while a quotient is still forming.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// Node store writes stay inside the store.
	a_waddr: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (32'(mem_waddr) <= 32'(MAX_PERIODS)))
		else $error("node write out of range");

	// A fold step only touches nodes below the current level width.
	a_fold_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FOLD_WR) |-> (i_q < lvl_q))
		else $error("fold index past level");

	// A new result only follows the finishing state.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside finish");

endmodule

FILE: rtl/core/bepr_divider.sv
// ----------------------------------------------------------------------------
// bepr_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bepr_divider #(
	parameter int DW = 34
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [31:0]   divisor,
	output logic          busy,
	output logic          done,
	output logic [DW-1:0] quotient
);
	localparam int CNTW = $clog2(DW + 1);

	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [31:0]     rem_q;
	logic [DW-1:0]   quo_q;
	logic [31:0]     dvs_q;
	logic [32:0]     shifted;
	logic            fits;

	assign shifted = {rem_q, quo_q[DW-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= 32'(shifted - {1'b0, dvs_q});
			end else begin
				rem_q <= shifted[31:0];
			end
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule
